// File: src/kline_request_frame_builder_core_defines.svh
// Assertion macros shared by the frame builder RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef KLINE_REQUEST_FRAME_BUILDER_CORE_DEFINES_SVH
`define KLINE_REQUEST_FRAME_BUILDER_CORE_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define KRFB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define KRFB_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// File: src/krfb_pkg.sv
`timescale 1ns / 1ps
// Package for the K-line request frame builder: request codes, register
// indexes, service bytes and the job record passed from front to back end.
package krfb_pkg;

  typedef enum logic [1:0] {
    REQ_DATA           = 2'd0,
    REQ_START_COMM     = 2'd1,
    REQ_TESTER_PRESENT = 2'd2,
    REQ_UNUSED         = 2'd3
  } req_kind_t;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE_CH0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_CH0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_CH0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_CH1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_CH1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_CH1 = 3'd5;

  localparam logic [7:0] SVC_START_COMM     = 8'h81;
  localparam logic [7:0] SVC_TESTER_PRESENT = 8'h3E;
  localparam logic [7:0] LONG_LEN_LIMIT     = 8'd64;

  // Most bytes one request can produce (header plus data plus checksum).
  localparam int unsigned JOB_BYTES = 5;

  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;       // bytes[0] goes out first
    logic [2:0]                count;       // 1..JOB_BYTES
    logic                      ends_frame;  // last byte is the checksum
  } job_t;

endpackage

// File: src/krfb_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, request decode and frame state.
// Accepted requests that make bytes become job records. Depends on krfb_pkg.
module krfb_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [krfb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                         cfg_data,
  input  logic                               in_push,
  input  logic [1:0]                         in_req_type,
  input  logic                               in_channel_sel,
  input  logic [7:0]                         in_payload_byte,
  input  logic [7:0]                         in_frame_length,
  input  logic                               jq_full,
  output logic                               jq_push,
  output krfb_pkg::job_t                     jq_job
);
  import krfb_pkg::*;

  logic [1:0] mode_r [2];
  logic [7:0] tgt_r  [2];
  logic [7:0] src_r  [2];

  logic       in_frame_r, in_frame_nxt;
  logic [7:0] bytes_rem_r, bytes_rem_nxt;
  logic [7:0] sum_r, sum_nxt;

  logic       accept;
  req_kind_t  kind;
  logic [7:0] len_eff;
  logic       is_long;
  logic [1:0] mode_sel;
  logic [7:0] tgt_sel;
  logic [7:0] src_sel;
  logic [7:0] fmt_data;
  logic [7:0] fmt_whole;
  logic [7:0] hdr_sum;
  logic [7:0] data_sum;
  logic [7:0] rem_left;
  logic [7:0] svc;
  logic [7:0] whole_sum;
  job_t       job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r[0] <= '0;
      mode_r[1] <= '0;
      tgt_r[0]  <= '0;
      tgt_r[1]  <= '0;
      src_r[0]  <= '0;
      src_r[1]  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE_CH0:   mode_r[0] <= cfg_data[1:0];
        CFG_TARGET_CH0: tgt_r[0]  <= cfg_data;
        CFG_SOURCE_CH0: src_r[0]  <= cfg_data;
        CFG_MODE_CH1:   mode_r[1] <= cfg_data[1:0];
        CFG_TARGET_CH1: tgt_r[1]  <= cfg_data;
        CFG_SOURCE_CH1: src_r[1]  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept    = in_push && !jq_full;
  assign kind      = req_kind_t'(in_req_type);
  assign len_eff   = (in_frame_length == 8'd0) ? 8'd1 : in_frame_length;
  assign is_long   = (len_eff >= LONG_LEN_LIMIT);
  assign mode_sel  = mode_r[in_channel_sel];
  assign tgt_sel   = tgt_r[in_channel_sel];
  assign src_sel   = src_r[in_channel_sel];
  assign fmt_data  = {mode_sel, 6'd0} | (is_long ? 8'd0 : len_eff);
  assign fmt_whole = {mode_sel, 6'd1};
  assign hdr_sum   = fmt_data + tgt_sel + src_sel + (is_long ? len_eff : 8'd0);
  assign data_sum  = (in_frame_r ? sum_r : hdr_sum) + in_payload_byte;
  assign rem_left  = (in_frame_r ? bytes_rem_r : len_eff) - 8'd1;
  assign svc       = (kind == REQ_START_COMM) ? SVC_START_COMM : SVC_TESTER_PRESENT;
  assign whole_sum = fmt_whole + tgt_sel + src_sel + svc;

  always_comb begin
    job           = '0;
    in_frame_nxt  = in_frame_r;
    bytes_rem_nxt = bytes_rem_r;
    sum_nxt       = sum_r;
    case (kind)
      REQ_DATA: begin
        if (!in_frame_r) begin
          job.bytes[0] = fmt_data;
          job.bytes[1] = tgt_sel;
          job.bytes[2] = src_sel;
          if (rem_left == 8'd0) begin
            job.bytes[3]   = in_payload_byte;
            job.bytes[4]   = data_sum;
            job.count      = 3'd5;
            job.ends_frame = 1'b1;
          end else if (is_long) begin
            job.bytes[3] = len_eff;
            job.bytes[4] = in_payload_byte;
            job.count    = 3'd5;
          end else begin
            job.bytes[3] = in_payload_byte;
            job.count    = 3'd4;
          end
        end else if (rem_left == 8'd0) begin
          job.bytes[0]   = in_payload_byte;
          job.bytes[1]   = data_sum;
          job.count      = 3'd2;
          job.ends_frame = 1'b1;
        end else begin
          job.bytes[0] = in_payload_byte;
          job.count    = 3'd1;
        end
        if (rem_left == 8'd0) begin
          in_frame_nxt  = 1'b0;
          bytes_rem_nxt = 8'd0;
          sum_nxt       = 8'd0;
        end else begin
          in_frame_nxt  = 1'b1;
          bytes_rem_nxt = rem_left;
          sum_nxt       = data_sum;
        end
      end
      REQ_START_COMM, REQ_TESTER_PRESENT: begin
        // Whole one-service frames are dropped while a data frame is open.
        if (!in_frame_r) begin
          job.bytes[0]   = fmt_whole;
          job.bytes[1]   = tgt_sel;
          job.bytes[2]   = src_sel;
          job.bytes[3]   = svc;
          job.bytes[4]   = whole_sum;
          job.count      = 3'd5;
          job.ends_frame = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      bytes_rem_r <= 8'd0;
      sum_r       <= 8'd0;
    end else if (accept) begin
      in_frame_r  <= in_frame_nxt;
      bytes_rem_r <= bytes_rem_nxt;
      sum_r       <= sum_nxt;
    end
  end

  assign jq_push = accept && (job.count != 3'd0);
  assign jq_job  = job;

  `include "kline_request_frame_builder_core_defines.svh"

  `KRFB_ASSERT(a_open_frame_has_bytes, in_frame_r |-> (bytes_rem_r != 8'd0), "open frame with zero bytes left")
  `KRFB_ASSERT(a_idle_sum_clear, !in_frame_r |-> (sum_r == 8'd0), "checksum not cleared between frames")

endmodule

// File: src/krfb_job_q.sv
`timescale 1ns / 1ps
// Job queue between front and back end, a small register FIFO.
// Depends on krfb_pkg for the job record.
module krfb_job_q #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  krfb_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output krfb_pkg::job_t head_job
);
  import krfb_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: src/krfb_back.sv
`timescale 1ns / 1ps
// Back end: serializes the head job one byte per cycle into a two-entry
// output FIFO for the result ports; stalls while full. Uses krfb_pkg.
module krfb_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           jq_empty,
  input  krfb_pkg::job_t jq_head,
  output logic           jq_pop,
  output logic           out_empty,
  input  logic           out_pop,
  output logic [7:0]     out_byte,
  output logic           out_frame_end
);
  import krfb_pkg::*;

  logic [2:0] idx_r, idx_nxt;
  logic       emit;
  logic       last;
  logic [7:0] emit_byte;
  logic       emit_end;

  logic [7:0] oq_byte_r [2];
  logic       oq_end_r  [2];
  logic       oq_wr_r, oq_wr_nxt;
  logic       oq_rd_r, oq_rd_nxt;
  logic [1:0] oq_cnt_r, oq_cnt_nxt;
  logic       oq_full;
  logic       do_out;

  assign oq_full   = (oq_cnt_r == 2'd2);
  assign out_empty = (oq_cnt_r == 2'd0);
  assign do_out    = out_pop && !out_empty;

  assign emit      = !jq_empty && !oq_full;
  assign last      = (idx_r == (jq_head.count - 3'd1));
  assign emit_byte = jq_head.bytes[idx_r];
  assign emit_end  = jq_head.ends_frame && last;
  assign jq_pop    = emit && last;

  always_comb begin
    idx_nxt = idx_r;
    if (emit) begin
      idx_nxt = last ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_comb begin
    oq_wr_nxt  = emit ? ~oq_wr_r : oq_wr_r;
    oq_rd_nxt  = do_out ? ~oq_rd_r : oq_rd_r;
    oq_cnt_nxt = oq_cnt_r;
    if (emit && !do_out) begin
      oq_cnt_nxt = oq_cnt_r + 2'd1;
    end else if (do_out && !emit) begin
      oq_cnt_nxt = oq_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= 3'd0;
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      idx_r    <= idx_nxt;
      oq_wr_r  <= oq_wr_nxt;
      oq_rd_r  <= oq_rd_nxt;
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      oq_byte_r[oq_wr_r] <= emit_byte;
      oq_end_r[oq_wr_r]  <= emit_end;
    end
  end

  assign out_byte      = oq_byte_r[oq_rd_r];
  assign out_frame_end = oq_end_r[oq_rd_r];

  `include "kline_request_frame_builder_core_defines.svh"

  `KRFB_ASSERT(a_oq_no_overflow, oq_cnt_r != 2'd3, "output FIFO count out of range")
  `KRFB_ASSERT(a_idx_in_job, !jq_empty |-> (idx_r < jq_head.count), "byte index past end of job")
  `KRFB_ASSERT(a_idx_holds_job, (idx_r != 3'd0) |-> !jq_empty, "job left the queue mid-serialization")

endmodule

// File: src/kline_request_frame_builder_core.sv
`timescale 1ns / 1ps
// Top level of the K-line (KWP2000) request frame builder.
// Instantiates krfb_front, krfb_job_q and krfb_back; uses krfb_pkg.
//
//   channel   handshake              payload
//   -------   --------------------   --------------------------------------
//   in        in_push / in_full      in_req_type, in_channel_sel,
//                                    in_payload_byte, in_frame_length
//   out       out_pop / out_empty    out_byte, out_frame_end
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Flow: a request is taken whenever the job queue has room, so requests may
//   arrive back to back. The back end drives one byte per cycle while the
//   output FIFO has room; a request makes 0 to 5 bytes, and the sustained
//   rate is set by that single serializer.
// Reset: rst_n is synchronous; it clears frame state, queues and registers.
// Stalls: a full output FIFO stalls the serializer, which fills the job
//   queue, which raises in_full. cfg_ready is always high.
module kline_request_frame_builder_core #(
  parameter int unsigned JOB_Q_DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [krfb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  // request input, queue style
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [1:0]                     in_req_type,
  input  logic                           in_channel_sel,
  input  logic [7:0]                     in_payload_byte,
  input  logic [7:0]                     in_frame_length,
  // frame byte output, queue style
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [7:0]                     out_byte,
  output logic                           out_frame_end
);
  import krfb_pkg::*;

  // Front end -> job queue
  logic jq_push;
  job_t jq_push_job;
  logic jq_full;

  // Job queue -> back end
  logic jq_pop;
  logic jq_empty;
  job_t jq_head;

  // The front end only ever stalls on a full job queue.
  assign in_full = jq_full;

  krfb_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_push         (in_push),
    .in_req_type     (in_req_type),
    .in_channel_sel  (in_channel_sel),
    .in_payload_byte (in_payload_byte),
    .in_frame_length (in_frame_length),
    .jq_full         (jq_full),
    .jq_push         (jq_push),
    .jq_job          (jq_push_job)
  );

  // Short decoupling queue: each job carries the full byte list of one
  // transaction, so the back end never looks at front-end state.
  krfb_job_q #(
    .DEPTH (JOB_Q_DEPTH)
  ) u_job_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (jq_push),
    .push_job (jq_push_job),
    .full     (jq_full),
    .pop      (jq_pop),
    .empty    (jq_empty),
    .head_job (jq_head)
  );

  krfb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .jq_empty      (jq_empty),
    .jq_head       (jq_head),
    .jq_pop        (jq_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_byte      (out_byte),
    .out_frame_end (out_frame_end)
  );

endmodule

// File: bench/kline_frame_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the K-line request frame builder: watches the config, request
// and frame byte channels, predicts each frame byte and compares in order.
// Depends on krfb_pkg for request codes, register indexes and service bytes.
module kline_frame_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [krfb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  input  logic                           in_push,
  input  logic                           in_full,
  input  logic [1:0]                     in_req_type,
  input  logic                           in_channel_sel,
  input  logic [7:0]                     in_payload_byte,
  input  logic [7:0]                     in_frame_length,
  input  logic                           out_empty,
  input  logic                           out_pop,
  input  logic [7:0]                     out_byte,
  input  logic                           out_frame_end,
  output int                             mismatch_count,
  output int                             bytes_outstanding,
  output int                             bytes_checked,
  output int                             frames_closed
);
  import krfb_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       closes;
  } frame_byte_t;

  frame_byte_t awaited_bytes[$];

  // shadow registers, per channel
  logic [1:0] mode_bits   [2];
  logic [7:0] target_addr [2];
  logic [7:0] source_addr [2];

  // data frame in progress
  logic       frame_open;
  logic [7:0] bytes_left;
  logic [7:0] frame_sum;

  task automatic report_mismatch(input string what);
    if (mismatch_count < 40) $display("[%0t] MISMATCH: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic await_byte(input logic [7:0] value, input logic closes);
    awaited_bytes.push_back({value, closes});
  endtask

  // Header, address, length, data, service and checksum bytes one request produces.
  task automatic encode_request(input req_kind_t kind, input logic ch,
                                input logic [7:0] data, input logic [7:0] len);
    logic [7:0] header;
    logic [7:0] service;
    logic [7:0] eff_len;
    eff_len = (len == 8'd0) ? 8'd1 : len;
    case (kind)
      REQ_DATA: begin
        if (!frame_open) begin
          header = {mode_bits[ch], 6'd0};
          // short frames carry the length in the format byte
          if (eff_len < LONG_LEN_LIMIT) header = header | eff_len;
          await_byte(header, 1'b0);
          await_byte(target_addr[ch], 1'b0);
          await_byte(source_addr[ch], 1'b0);
          frame_sum = header + target_addr[ch] + source_addr[ch];
          if (eff_len >= LONG_LEN_LIMIT) begin
            await_byte(eff_len, 1'b0);
            frame_sum = frame_sum + eff_len;
          end
          bytes_left = eff_len;
          frame_open = 1'b1;
        end
        await_byte(data, 1'b0);
        frame_sum  = frame_sum + data;
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'd0) begin
          await_byte(frame_sum, 1'b1);
          frame_open = 1'b0;
          frame_sum  = 8'd0;
        end
      end
      REQ_START_COMM, REQ_TESTER_PRESENT: begin
        // dropped while a data frame is open
        if (!frame_open) begin
          service = (kind == REQ_START_COMM) ? SVC_START_COMM : SVC_TESTER_PRESENT;
          header  = {mode_bits[ch], 6'd1};
          await_byte(header, 1'b0);
          await_byte(target_addr[ch], 1'b0);
          await_byte(source_addr[ch], 1'b0);
          await_byte(service, 1'b0);
          await_byte(header + target_addr[ch] + source_addr[ch] + service, 1'b1);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    frame_byte_t want;
    if (!rst_n) begin
      for (int c = 0; c < 2; c++) begin
        mode_bits[c]   = 2'd0;
        target_addr[c] = 8'd0;
        source_addr[c] = 8'd0;
      end
      frame_open = 1'b0;
      bytes_left = 8'd0;
      frame_sum  = 8'd0;
      awaited_bytes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODE_CH0:   mode_bits[0]   = cfg_data[1:0];
          CFG_TARGET_CH0: target_addr[0] = cfg_data;
          CFG_SOURCE_CH0: source_addr[0] = cfg_data;
          CFG_MODE_CH1:   mode_bits[1]   = cfg_data[1:0];
          CFG_TARGET_CH1: target_addr[1] = cfg_data;
          CFG_SOURCE_CH1: source_addr[1] = cfg_data;
          default: ;
        endcase
      end
      if (in_push && !in_full)
        encode_request(req_kind_t'(in_req_type), in_channel_sel, in_payload_byte,
                       in_frame_length);
      if (out_pop && !out_empty) begin
        if (awaited_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h end=%0b", out_byte, out_frame_end));
        end else begin
          want = awaited_bytes.pop_front();
          bytes_checked++;
          if (want.closes) frames_closed++;
          if (out_byte !== want.value)
            report_mismatch($sformatf("out_byte %02h, predicted %02h", out_byte, want.value));
          if (out_frame_end !== want.closes)
            report_mismatch($sformatf("out_frame_end %0b, predicted %0b on byte %02h",
                                      out_frame_end, want.closes, want.value));
        end
      end
    end
    bytes_outstanding = awaited_bytes.size();
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Top of the frame builder bench: clock, reset, request and register stimulus,
// output pacing and the verdict. Needs krfb_pkg, the core and kline_frame_checker.
module testbench;
  import krfb_pkg::*;

  localparam int RANDOM_ITEMS  = 190;
  localparam int SETTLE_CYCLES = 16;     // covers job queue plus output FIFO
  localparam int CYCLE_LIMIT   = 400000;

  // receiver pacing styles
  typedef enum int {
    POP_ALWAYS,
    POP_COIN,
    POP_QUARTER,
    POP_SPARSE
  } pop_style_t;

  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 cfg_valid       = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index       = CFG_MODE_CH0;
  logic [7:0]           cfg_data        = 8'd0;
  logic                 in_push         = 1'b0;
  logic                 in_full;
  logic [1:0]           in_req_type     = REQ_DATA;
  logic                 in_channel_sel  = 1'b0;
  logic [7:0]           in_payload_byte = 8'd0;
  logic [7:0]           in_frame_length = 8'd1;
  logic                 out_empty;
  logic                 out_pop         = 1'b0;
  logic [7:0]           out_byte;
  logic                 out_frame_end;

  int mismatch_count;
  int bytes_outstanding;
  int bytes_checked;
  int frames_closed;

  int         cycle_count   = 0;
  int         items_sent    = 0;
  int         useful_items  = 0;   // requests that the core acts on
  int         settings_used = 0;
  int         burst_left    = 0;
  pop_style_t pop_style     = POP_ALWAYS;
  int         pop_phase     = 0;

  always #10 clk = ~clk;

  kline_request_frame_builder_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_req_type     (in_req_type),
    .in_channel_sel  (in_channel_sel),
    .in_payload_byte (in_payload_byte),
    .in_frame_length (in_frame_length),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_byte        (out_byte),
    .out_frame_end   (out_frame_end)
  );

  kline_frame_checker frame_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_req_type       (in_req_type),
    .in_channel_sel    (in_channel_sel),
    .in_payload_byte   (in_payload_byte),
    .in_frame_length   (in_frame_length),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_byte          (out_byte),
    .out_frame_end     (out_frame_end),
    .mismatch_count    (mismatch_count),
    .bytes_outstanding (bytes_outstanding),
    .bytes_checked     (bytes_checked),
    .frames_closed     (frames_closed)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Cycle limit reached with %0d frame bytes still outstanding",
               bytes_outstanding);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: pop style is redrawn each time pop_phase runs out, so stalls land on
  // header, payload and checksum bytes alike; POP_ALWAYS gives stall-free runs.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (pop_phase == 0) begin
        pop_style = pop_style_t'($urandom_range(0, 3));
        pop_phase = $urandom_range(20, 80);
      end else begin
        pop_phase--;
      end
      case (pop_style)
        POP_ALWAYS:  out_pop <= 1'b1;
        POP_COIN:    out_pop <= 1'($urandom_range(0, 1));
        POP_QUARTER: out_pop <= (pop_phase[1:0] == 2'd0);
        default:     out_pop <= (pop_phase[3:0] == 4'd0);
      endcase
    end
  end

  // Sender bursts: a random gap opens every burst, some bursts are long.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 10);
    end
    burst_left--;
  endtask

  // One request transaction; push stays high so the next one can follow
  // back to back.
  task automatic send_request(input req_kind_t kind, input logic ch,
                              input logic [7:0] data, input logic [7:0] len);
    pace_sender();
    in_push         <= 1'b1;
    in_req_type     <= kind;
    in_channel_sel  <= ch;
    in_payload_byte <= data;
    in_frame_length <= len;
    @(posedge clk);
    while (in_full) @(posedge clk);
    items_sent++;
  endtask

  // Wait until every predicted byte has been popped, then let any request
  // that makes no bytes clear the pipeline.
  task automatic drain_frames();
    in_push <= 1'b0;
    @(negedge clk);
    while (bytes_outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value,
                                input logic last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (last) cfg_valid <= 1'b0;
  endtask

  // Writes all six registers back to back. Mode writes carry full bytes;
  // only bits 1:0 are kept.
  task automatic program_channels(input logic [7:0] m0, input logic [7:0] t0,
                                  input logic [7:0] s0, input logic [7:0] m1,
                                  input logic [7:0] t1, input logic [7:0] s1);
    write_register(CFG_MODE_CH0,   m0, 1'b0);
    write_register(CFG_TARGET_CH0, t0, 1'b0);
    write_register(CFG_SOURCE_CH0, s0, 1'b0);
    write_register(CFG_MODE_CH1,   m1, 1'b0);
    write_register(CFG_TARGET_CH1, t1, 1'b0);
    write_register(CFG_SOURCE_CH1, s1, 1'b1);
    settings_used++;
  endtask

  // Random byte biased toward 0x00 and 0xFF.
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // Unused kind, or a whole-frame request (dropped if a data frame is open).
  task automatic send_noise();
    req_kind_t kind;
    case ($urandom_range(0, 2))
      0:       kind = REQ_UNUSED;
      1:       kind = REQ_START_COMM;
      default: kind = REQ_TESTER_PRESENT;
    endcase
    send_request(kind, 1'($urandom_range(0, 1)), pick_byte(), pick_byte());
  endtask

  // A well-formed data frame; channel and length only matter on the first
  // item, later ones carry junk there. Noise is sprinkled in between.
  task automatic send_data_frame(input logic [7:0] len);
    int  count;
    logic ch;
    count = (len == 8'd0) ? 1 : len;
    ch    = 1'($urandom_range(0, 1));
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      if (i == 0)
        send_request(REQ_DATA, ch, pick_byte(), len);
      else
        send_request(REQ_DATA, 1'($urandom_range(0, 1)), pick_byte(), pick_byte());
      useful_items++;
    end
  endtask

  initial begin
    int         roll;
    int         last_program;
    logic [7:0] len;
    logic       did_boundary;

    did_boundary = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed: registers still at their reset value of zero ---
    send_request(REQ_START_COMM,     1'b0, 8'h00, 8'h00);
    send_request(REQ_TESTER_PRESENT, 1'b1, 8'hFF, 8'hFF);
    send_request(REQ_DATA,           1'b0, 8'h00, 8'd1);
    send_request(REQ_UNUSED,         1'b1, 8'hFF, 8'hFF);
    drain_frames();

    // extremes: mode 3 and all-ones addresses on ch0, mode 2 on ch1
    program_channels(8'hFF, 8'hFF, 8'hFF, 8'h02, 8'h00, 8'h80);

    // zero length is taken as one
    send_request(REQ_DATA,           1'b1, 8'hFF, 8'd0);
    send_request(REQ_TESTER_PRESENT, 1'b0, 8'h00, 8'h00);
    send_request(REQ_START_COMM,     1'b1, 8'h00, 8'h00);
    // three-byte frame with whole-frame requests and an unused kind inside,
    // and changed channel/length on later items
    send_request(REQ_DATA,           1'b0, 8'hA5, 8'd3);
    send_request(REQ_TESTER_PRESENT, 1'b1, 8'h00, 8'h00);
    send_request(REQ_DATA,           1'b1, 8'h5A, 8'hFF);
    send_request(REQ_START_COMM,     1'b0, 8'h00, 8'h00);
    send_request(REQ_UNUSED,         1'b0, 8'h00, 8'h00);
    send_request(REQ_DATA,           1'b1, 8'h01, 8'd0);
    // register write between the first and second item: header stays as sent
    send_request(REQ_DATA,           1'b1, 8'h7E, 8'd2);
    drain_frames();
    write_register(CFG_SOURCE_CH1, 8'h11, 1'b1);
    send_request(REQ_DATA,           1'b0, 8'h81, 8'd40);
    send_request(REQ_START_COMM,     1'b1, 8'h00, 8'h00);
    drain_frames();

    // --- random: mostly well-formed frames, some whole frames and noise ---
    useful_items = 0;
    last_program = 0;
    while (useful_items < RANDOM_ITEMS) begin
      if (useful_items - last_program >= 40) begin
        drain_frames();
        program_channels(8'($urandom_range(0, 255)), pick_byte(), pick_byte(),
                         8'($urandom_range(0, 255)), pick_byte(), pick_byte());
        last_program = useful_items;
      end
      if (!did_boundary && useful_items >= 20) begin
        // first length that moves into the extra length byte
        send_data_frame(LONG_LEN_LIMIT);
        did_boundary = 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
          roll = $urandom_range(0, 99);
          if (roll < 5)       len = 8'd0;
          else if (roll < 80) len = 8'($urandom_range(1, 8));
          else if (roll < 95) len = 8'($urandom_range(9, 63));
          else                len = 8'($urandom_range(64, 100));
          send_data_frame(len);
        end else if (roll < 90) begin
          send_request((roll < 78) ? REQ_START_COMM : REQ_TESTER_PRESENT,
                       1'($urandom_range(0, 1)), pick_byte(), pick_byte());
          useful_items++;
        end else begin
          send_noise();
        end
      end
    end

    // longest length: header with the extra length byte and a few payload
    // items; the frame stays open to the end of the run
    drain_frames();
    send_request(REQ_DATA, 1'($urandom_range(0, 1)), pick_byte(), 8'd255);
    for (int i = 0; i < 4; i++)
      send_request(REQ_DATA, 1'($urandom_range(0, 1)), pick_byte(), pick_byte());

    drain_frames();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);

    $display("Run: %0d requests under %0d register settings, %0d bytes in %0d frames checked",
             items_sent, settings_used, bytes_checked, frames_closed);
    $display("Included zero, boundary and maximum lengths, dropped requests, mid-frame write");
    if (mismatch_count == 0 && bytes_outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
